[hw/rtl/clock_page_replacement_core_macros.svh]
// ----------------------------------------------------------------------------
// Clock page replacement core: assertion macros
// Shared assertion shorthands, sampled on clk; CPR_ASSERT is held off during rst.
// ----------------------------------------------------------------------------
`ifndef CLOCK_PAGE_REPLACEMENT_CORE_MACROS_SVH
`define CLOCK_PAGE_REPLACEMENT_CORE_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define CPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same, for properties that also hold while reset is applied.
`define CPR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/cpr_pkg.sv]
// ----------------------------------------------------------------------------
// Clock page replacement package
// Widths, request codes and sequencer states shared by the core files.
// ----------------------------------------------------------------------------
package cpr_pkg;

  localparam int MAX_FRAMES = 1024;
  localparam int ADDR_W     = $clog2(MAX_FRAMES);
  localparam int FRAME_W    = 10;
  localparam int CNT_W      = 11;

  localparam logic KIND_REF   = 1'b0;
  localparam logic KIND_FAULT = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_RESULT
  } cpr_state_t;

endpackage

[hw/rtl/cpr_req_if.sv]
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one reference or fault request per transfer.
// ----------------------------------------------------------------------------
interface cpr_req_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [cpr_pkg::FRAME_W-1:0] frame;

  modport source (output valid, kind, frame, input ready);
  modport sink   (input valid, kind, frame, output ready);
endinterface

[hw/rtl/cpr_res_if.sv]
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one granted frame per transfer.
// ----------------------------------------------------------------------------
interface cpr_res_if;
  logic                        valid;
  logic                        ready;
  logic [cpr_pkg::FRAME_W-1:0] granted_frame;
  logic                        replaced;

  modport source (output valid, granted_frame, replaced, input ready);
  modport sink   (input valid, granted_frame, replaced, output ready);
endinterface

[hw/rtl/cpr_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered (old data on collision).
// ----------------------------------------------------------------------------
module cpr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hw/rtl/clock_page_replacement_core.sv]
// ----------------------------------------------------------------------------
// Clock page replacement core
// Second-chance frame chooser; referenced bits live in a 1-bit RAM.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                 | transfer
//  req      | in  | kind, frame             | req.valid & req.ready
//  res      | out | granted_frame, replaced | res.valid & res.ready
//  cfg      | in  | cfg_wr_data (ring size) | cfg_wr_en
//
//  Reference and free-frame allocation: ST_IDLE, ST_RESULT, output register.
//  Victim search: ST_CHECK repeats for each frame with the bit set passed by the
//  hand; one RAM read-modify-write per cycle bounds the sweep.
//  Reset: a clearing pass over all 1024 RAM entries; req.ready stays low.
//  A stalled result holds in the output register; the next request is taken
//  meanwhile and waits in its result state until the register frees.
// ----------------------------------------------------------------------------
`include "clock_page_replacement_core_macros.svh"

module clock_page_replacement_core (
  input  logic                      clk,
  input  logic                      rst,
  cpr_req_if.sink                   req,
  cpr_res_if.source                 res,
  input  logic                      cfg_wr_en,
  input  logic [cpr_pkg::CNT_W-1:0] cfg_wr_data
);

  localparam int AW = cpr_pkg::ADDR_W;
  localparam int CW = cpr_pkg::CNT_W;
  localparam int FW = cpr_pkg::FRAME_W;

  cpr_pkg::cpr_state_t state, state_next;

  logic [CW-1:0] frames_in_use;
  logic [AW-1:0] hand, hand_next;
  logic [CW-1:0] handed, handed_next;
  logic [AW-1:0] clr_addr, clr_addr_next;
  logic          fwd, fwd_next;
  logic [FW-1:0] res_frame, res_frame_next;
  logic          res_rep, res_rep_next;

  logic          out_valid;
  logic [FW-1:0] out_frame;
  logic          out_rep;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [0:0]    wr_data;
  logic [AW-1:0] rd_addr;
  logic [0:0]    rd_data;

  logic [CW-1:0] ring_n;
  logic [AW-1:0] hand_wrap;
  logic [CW-1:0] hand_inc;
  logic [AW-1:0] hand_adv;
  logic          pool_full;
  logic          accept;
  logic          bit_set;
  logic          out_load;
  logic          clr_done;
  logic          in_idle;
  logic          in_check;

  cpr_ram #(.WIDTH(1), .DEPTH(cpr_pkg::MAX_FRAMES)) u_ref_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign ring_n = (frames_in_use == '0) ? CW'(1) :
                  (frames_in_use > CW'(cpr_pkg::MAX_FRAMES)) ? CW'(cpr_pkg::MAX_FRAMES) :
                  frames_in_use;
  assign hand_wrap = ({1'b0, hand} >= ring_n) ? '0 : hand;
  assign hand_inc  = CW'(hand) + CW'(1);
  assign hand_adv  = (hand_inc >= ring_n) ? '0 : hand_inc[AW-1:0];
  assign pool_full = handed >= ring_n;
  assign accept    = req.valid && req.ready;
  assign bit_set   = rd_data[0] && !fwd;
  assign out_load  = (state == cpr_pkg::ST_RESULT) && (!out_valid || res.ready);
  assign clr_done  = clr_addr == AW'(cpr_pkg::MAX_FRAMES - 1);
  assign in_idle   = state == cpr_pkg::ST_IDLE;
  assign in_check  = state == cpr_pkg::ST_CHECK;

  assign req.ready         = state == cpr_pkg::ST_IDLE;
  assign res.valid         = out_valid;
  assign res.granted_frame = out_frame;
  assign res.replaced      = out_rep;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      cpr_pkg::ST_CLEAR: begin
        if (clr_done) state_next = cpr_pkg::ST_IDLE;
      end
      cpr_pkg::ST_IDLE: begin
        if (accept) begin
          if (req.kind == cpr_pkg::KIND_FAULT && pool_full) begin
            state_next = cpr_pkg::ST_CHECK;
          end else begin
            state_next = cpr_pkg::ST_RESULT;
          end
        end
      end
      cpr_pkg::ST_CHECK: begin
        if (!bit_set) state_next = cpr_pkg::ST_RESULT;
      end
      cpr_pkg::ST_RESULT: begin
        if (out_load) state_next = cpr_pkg::ST_IDLE;
      end
      default: state_next = cpr_pkg::ST_CLEAR;
    endcase
  end

  // outputs and datapath
  always_comb begin
    wr_en          = 1'b0;
    wr_addr        = hand;
    wr_data        = 1'b0;
    rd_addr        = hand;
    hand_next      = hand;
    handed_next    = handed;
    clr_addr_next  = clr_addr;
    fwd_next       = 1'b0;
    res_frame_next = res_frame;
    res_rep_next   = res_rep;
    unique case (state)
      cpr_pkg::ST_CLEAR: begin
        wr_en         = 1'b1;
        wr_addr       = clr_addr;
        clr_addr_next = clr_addr + AW'(1);
      end
      cpr_pkg::ST_IDLE: begin
        if (accept) begin
          if (req.kind == cpr_pkg::KIND_REF) begin
            wr_en          = {{(CW-FW){1'b0}}, req.frame} < CW'(cpr_pkg::MAX_FRAMES);
            wr_addr        = AW'(req.frame);
            wr_data        = 1'b1;
            res_frame_next = req.frame;
            res_rep_next   = 1'b0;
          end else if (!pool_full) begin
            wr_en          = 1'b1;
            wr_addr        = handed[AW-1:0];
            handed_next    = handed + CW'(1);
            res_frame_next = FW'(handed[AW-1:0]);
            res_rep_next   = 1'b0;
          end else begin
            hand_next = hand_wrap;
            rd_addr   = hand_wrap;
          end
        end
      end
      cpr_pkg::ST_CHECK: begin
        if (bit_set) begin
          wr_en     = 1'b1;
          wr_addr   = hand;
          hand_next = hand_adv;
          rd_addr   = hand_adv;
          // one-frame ring: re-read of the entry just cleared
          fwd_next  = hand_adv == hand;
        end else begin
          res_frame_next = FW'(hand);
          res_rep_next   = 1'b1;
        end
      end
      cpr_pkg::ST_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= cpr_pkg::ST_CLEAR;
      frames_in_use <= CW'(cpr_pkg::MAX_FRAMES);
      hand          <= '0;
      handed        <= '0;
      clr_addr      <= '0;
      fwd           <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state    <= state_next;
      hand     <= hand_next;
      handed   <= handed_next;
      clr_addr <= clr_addr_next;
      fwd      <= fwd_next;
      if (cfg_wr_en) frames_in_use <= cfg_wr_data;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_frame <= res_frame_next;
    res_rep   <= res_rep_next;
    if (out_load) begin
      out_frame <= res_frame;
      out_rep   <= res_rep;
    end
  end

  `CPR_ASSERT(a_check_entry, in_check |-> $past(in_idle || in_check), "bad sweep entry")
  `CPR_ASSERT(a_hand_in_ring, in_check |-> {1'b0, hand} < ring_n, "hand outside ring")
  `CPR_ASSERT(a_load_shows, out_load |=> out_frame == $past(res_frame), "result not shown")
  `CPR_ASSERT(a_handed_bound, handed <= CW'(cpr_pkg::MAX_FRAMES), "handed out beyond pool")

endmodule

[dv/tb_clock_page_replacement_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Clock page replacement core testbench
// Drives reference and fault requests through the request channel, keeps a
// second-chance model of the frame pool and compares every granted frame.
// Ring size changes between phases, including out-of-range and shrinking.
// ----------------------------------------------------------------------------
module tb_clock_page_replacement_core;

  localparam int MAX_FRAMES  = cpr_pkg::MAX_FRAMES;
  localparam int FRAME_W     = cpr_pkg::FRAME_W;
  localparam int CNT_W       = cpr_pkg::CNT_W;
  localparam int QUIET_LIMIT = 8000;
  localparam int LONG_HOLD   = 300;

  typedef struct packed {
    logic               kind;
    logic [FRAME_W-1:0] frame;
  } page_req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] granted_frame;
    logic               replaced;
  } grant_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [CNT_W-1:0] cfg_wr_data;

  cpr_req_if req_ch ();
  cpr_res_if res_ch ();

  clock_page_replacement_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .res         (res_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // pool model
  bit             referenced [MAX_FRAMES];
  int unsigned    hand;
  int unsigned    handed_out;
  logic [CNT_W-1:0] ring_cfg;

  page_req_t page_req_q[$];
  grant_t    grant_q[$];

  int unsigned n_refs, n_fresh, n_victims, longest_sweep, n_checked, errors;
  int unsigned req_done, quiet_cycles;
  int unsigned req_idle_left, res_hold_left;
  int unsigned req_idle_pct, res_hold_pct;
  bit          calm, long_hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned ring_eff(input logic [CNT_W-1:0] v);
    if (v < 1) return 1;
    if (v > MAX_FRAMES) return MAX_FRAMES;
    return 32'(v);
  endfunction

  function automatic grant_t predict_grant(input page_req_t r);
    grant_t      g;
    int unsigned ring;
    int unsigned sweep;
    ring  = ring_eff(ring_cfg);
    sweep = 0;
    if (r.kind == cpr_pkg::KIND_REF) begin
      referenced[r.frame] = 1'b1;
      g.granted_frame = r.frame;
      g.replaced      = 1'b0;
      n_refs++;
    end else if (handed_out < ring) begin
      g.granted_frame = handed_out[FRAME_W-1:0];
      g.replaced      = 1'b0;
      referenced[handed_out] = 1'b0;
      handed_out++;
      n_fresh++;
    end else begin
      if (hand >= ring) hand = 0;
      while (referenced[hand]) begin
        referenced[hand] = 1'b0;
        hand++;
        sweep++;
        if (hand >= ring) hand = 0;
      end
      referenced[hand] = 1'b0;
      g.granted_frame = hand[FRAME_W-1:0];
      g.replaced      = 1'b1;
      n_victims++;
      if (sweep > longest_sweep) longest_sweep = sweep;
    end
    return g;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid  <= 1'b0;
      req_ch.kind   <= cpr_pkg::KIND_REF;
      req_ch.frame  <= '0;
      req_idle_left = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        grant_q.push_back(predict_grant('{kind: req_ch.kind, frame: req_ch.frame}));
        req_done++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (req_idle_left > 0) begin
          req_idle_left--;
          req_ch.valid <= 1'b0;
        end else if (!calm && $urandom_range(99) < req_idle_pct) begin
          req_idle_left = $urandom_range(1, 16) - 1;
          req_ch.valid <= 1'b0;
        end else if (page_req_q.size() > 0) begin
          req_ch.valid <= 1'b1;
          req_ch.kind  <= page_req_q[0].kind;
          req_ch.frame <= page_req_q[0].frame;
          void'(page_req_q.pop_front());
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result ready: random holds plus one long hold-off to back up the core
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      res_hold_left = 0;
    end else if (res_hold_left > 0) begin
      res_hold_left--;
      res_ch.ready <= 1'b0;
    end else if (!long_hold_done && req_done >= 520 && page_req_q.size() > 30) begin
      long_hold_done = 1'b1;
      res_hold_left  = LONG_HOLD - 1;
      res_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(99) < res_hold_pct) begin
      res_hold_left = $urandom_range(1, 16) - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    grant_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (grant_q.size() == 0) begin
        $error("result with nothing pending: granted_frame %0d replaced %0d",
               res_ch.granted_frame, res_ch.replaced);
        errors++;
      end else begin
        want = grant_q.pop_front();
        n_checked++;
        if (res_ch.granted_frame !== want.granted_frame) begin
          $error("granted_frame: expected %0d, got %0d", want.granted_frame,
                 res_ch.granted_frame);
          errors++;
        end
        if (res_ch.replaced !== want.replaced) begin
          $error("replaced: expected %0d, got %0d", want.replaced, res_ch.replaced);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results pending",
               QUIET_LIMIT, grant_q.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_req(input logic kind, input logic [FRAME_W-1:0] frame);
    page_req_q.push_back('{kind: kind, frame: frame});
  endtask

  // mostly frames inside the ring, some anywhere in the 10-bit range
  task automatic queue_mix(input int unsigned count, input int unsigned fault_pct);
    int unsigned ring;
    ring = ring_eff(ring_cfg);
    repeat (count) begin
      if ($urandom_range(99) < fault_pct)
        push_req(cpr_pkg::KIND_FAULT, FRAME_W'($urandom));
      else if ($urandom_range(7) == 0)
        push_req(cpr_pkg::KIND_REF, FRAME_W'($urandom));
      else
        push_req(cpr_pkg::KIND_REF, FRAME_W'($urandom_range(0, ring - 1)));
    end
  endtask

  task automatic settle;
    while (page_req_q.size() != 0 || req_ch.valid || grant_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_ring(input logic [CNT_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    ring_cfg = v;
  endtask

  task automatic run_phase(input logic [CNT_W-1:0] v, input int unsigned count,
                           input int unsigned fault_pct, input int unsigned idle_pct);
    set_ring(v);
    req_idle_pct = idle_pct;
    res_hold_pct = $urandom_range(0, 2) * idle_pct;
    queue_mix(count, fault_pct);
    settle();
  endtask

  initial begin
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    ring_cfg     = CNT_W'(MAX_FRAMES);
    req_idle_pct = 0;
    res_hold_pct = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset ring size, field extremes, fresh allocations
    push_req(cpr_pkg::KIND_REF, 10'h3FF);
    push_req(cpr_pkg::KIND_REF, 10'h000);
    push_req(cpr_pkg::KIND_REF, 10'h2AA);
    push_req(cpr_pkg::KIND_REF, 10'h155);
    push_req(cpr_pkg::KIND_FAULT, 10'h3FF);
    push_req(cpr_pkg::KIND_FAULT, 10'h000);
    push_req(cpr_pkg::KIND_FAULT, 10'h2AA);
    settle();

    // pool already over a two-frame ring; full turn plus one
    set_ring(CNT_W'(2));
    push_req(cpr_pkg::KIND_FAULT, 10'h000);
    push_req(cpr_pkg::KIND_REF, 10'h000);
    push_req(cpr_pkg::KIND_REF, 10'h001);
    push_req(cpr_pkg::KIND_FAULT, 10'h155);
    push_req(cpr_pkg::KIND_REF, 10'h3FF);
    push_req(cpr_pkg::KIND_REF, 10'h001);
    push_req(cpr_pkg::KIND_FAULT, 10'h000);
    settle();

    // zero ring size acts as one
    set_ring(CNT_W'(0));
    push_req(cpr_pkg::KIND_FAULT, 10'h000);
    push_req(cpr_pkg::KIND_REF, 10'h000);
    push_req(cpr_pkg::KIND_FAULT, 10'h3FF);
    settle();

    // oversize ring acts as the full pool
    set_ring(11'h7FF);
    push_req(cpr_pkg::KIND_FAULT, 10'h000);
    push_req(cpr_pkg::KIND_REF, 10'h005);
    push_req(cpr_pkg::KIND_FAULT, 10'h000);
    settle();

    run_phase(11'h7FF, 60, 30, 10);
    run_phase(CNT_W'(12), 80, 35, 5);
    run_phase(CNT_W'(4), 60, 40, 15);
    run_phase(CNT_W'(1), 30, 40, 0);
    run_phase(CNT_W'($urandom_range(1, 64)), 90, 30, 10);
    run_phase(CNT_W'($urandom_range(1, 64)), 90, 30, 5);
    run_phase(CNT_W'(MAX_FRAMES), 100, 20, 10);
    run_phase(CNT_W'($urandom_range(16, 40)), 120, 30, 5);
    calm = 1'b1;
    run_phase(CNT_W'($urandom_range(2, 24)), 70, 35, 0);

    repeat (20) @(posedge clk);
    if (grant_q.size() != 0) begin
      $error("%0d expected results never arrived", grant_q.size());
      errors++;
    end
    $display("covered %0d references, %0d fresh frames, %0d victims (longest sweep %0d)",
             n_refs, n_fresh, n_victims, longest_sweep);
    $display("%0d results checked across ring sizes 0..2047, with stalls on both sides",
             n_checked);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/cpr_pkg.sv
hw/rtl/cpr_req_if.sv
hw/rtl/cpr_res_if.sv
hw/rtl/cpr_ram.sv
hw/rtl/clock_page_replacement_core.sv
dv/tb_clock_page_replacement_core.sv
